/* hw/rtl/lkvc_pkg.sv */
`timescale 1ns / 1ps

package lkvc_pkg;

	// default number of cache entries
	localparam int DEF_ENTRIES = 16;

	// field widths
	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int CAP_W   = 5;

	// capacity register reset value
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// operation codes
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	// fixed result values
	localparam logic [VALUE_W-1:0] MISS_VALUE = '1;
	localparam logic [VALUE_W-1:0] PUT_VALUE  = '0;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic lookup;
		logic update;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_blocked;
	} status_t;

endpackage

/* hw/rtl/lru_key_value_cache.sv */
// Fully associative key/value cache with least-recently-used replacement.
// Request channel: in_valid / in_stall with kind (0 get, 1 put), key and
// value; a transfer happens on a rising edge with in_valid high and in_stall
// low. Result channel: out_valid / out_stall with hit and read_value, one
// result per request, in request order.
// Configuration: cfg_valid / cfg_ready with capacity; cfg_ready is always
// high. Write it only while no request is in flight.
// A request passes the capture registers, the lookup registers and the
// result register in turn: a lookup step for the parallel key compare over
// all entries, then an update step for the recency rank update and value
// store write; the next request is taken during the update step.
// When out_stall holds a result, the update of the following request waits
// and in_stall rises until the result register frees.
// Reset clears valid marks, ranks, the entry count and the result valid bit,
// and sets capacity to 16; the block takes requests right after reset.
`timescale 1ns / 1ps

module lru_key_value_cache #(
	parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic signed [lkvc_pkg::KEY_W-1:0]   key,
	input  logic signed [lkvc_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic signed [lkvc_pkg::VALUE_W-1:0] read_value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0]          capacity
);

	import lkvc_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    cfg_we;

	// configuration is always accepted
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lkvc_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.kind       (kind),
		.key        (key),
		.value      (value),
		.cfg_we     (cfg_we),
		.capacity   (capacity),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.hit        (hit),
		.read_value (read_value)
	);

`ifndef NO_ASSERTIONS
	// no request is taken in the cycle after a transfer (lookup in progress)
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken during lookup");

	// captured request registers never change while a lookup reads them
	a_capture_not_in_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !cmd.lookup)
		else $error("capture during lookup");

	// every completed update presents a result
	a_update_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid)
		else $error("update without result");
`endif

endmodule

/* hw/rtl/lkvc_ram.sv */
`timescale 1ns / 1ps

module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/lkvc_ctrl.sv */
`timescale 1ns / 1ps

module lkvc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lkvc_pkg::status_t status,
	output lkvc_pkg::cmd_t    cmd
);

	import lkvc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   take;
	logic   finish;

	// an item is taken when idle or while the current one completes
	assign finish   = (state_q == ST_UPDATE) && !status.out_blocked;
	assign in_stall = !((state_q == ST_IDLE) || finish);
	assign take     = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (finish) begin
					state_d = take ? ST_LOOKUP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.capture = take;
		cmd.lookup  = 1'b0;
		cmd.update  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = finish;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/lkvc_datapath.sv */
`timescale 1ns / 1ps

module lkvc_datapath #(
	parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lkvc_pkg::cmd_t                      cmd,
	output lkvc_pkg::status_t                   status,
	input  logic                                kind,
	input  logic signed [lkvc_pkg::KEY_W-1:0]   key,
	input  logic signed [lkvc_pkg::VALUE_W-1:0] value,
	input  logic                                cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]          capacity,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic                                hit,
	output logic signed [lkvc_pkg::VALUE_W-1:0] read_value
);

	import lkvc_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int MW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// captured request
	logic               kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;

	// entry state
	logic [KEY_W-1:0] keys_q  [ENTRIES];
	logic [IDX_W-1:0] rank_q  [ENTRIES];
	logic             valid_q [ENTRIES];
	logic [CNT_W-1:0] count_q;
	logic [CAP_W-1:0] cap_q;

	// lookup results
	logic             hit_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] rank_s1;

	// result register
	logic               out_valid_q;
	logic               hit_q;
	logic [VALUE_W-1:0] read_value_q;

	logic [ENTRIES-1:0] match;
	logic [IDX_W-1:0]   match_idx;
	logic [IDX_W-1:0]   match_rank;
	logic [ENTRIES-1:0] evict;
	logic [IDX_W-1:0]   new_idx;
	logic               need_evict;
	logic [MW-1:0]      cap_ext;
	logic [MW-1:0]      eff_ext;
	logic [CNT_W-1:0]   eff_cap;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [VALUE_W-1:0] ram_rdata;

	// effective capacity: zero acts as one, clamp to the entry count
	always_comb begin
		cap_ext = MW'(cap_q);
		if (cap_ext == '0) begin
			eff_ext = MW'(1);
		end else if (cap_ext > MW'(ENTRIES)) begin
			eff_ext = MW'(ENTRIES);
		end else begin
			eff_ext = cap_ext;
		end
		eff_cap = CNT_W'(eff_ext);
	end

	// parallel key compare, one-hot match encoded to index and rank
	always_comb begin
		match_idx  = '0;
		match_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (keys_q[i] == key_q);
			if (match[i]) begin
				match_idx  = match_idx | IDX_W'(i);
				match_rank = match_rank | rank_q[i];
			end
		end
	end

	// eviction set and first free or evicted slot for a new key
	always_comb begin
		logic found;
		found      = 1'b0;
		new_idx    = '0;
		need_evict = (count_q >= eff_cap);
		for (int i = 0; i < ENTRIES; i++) begin
			evict[i] = need_evict && valid_q[i] &&
				(CNT_W'(rank_q[i]) >= (eff_cap - CNT_W'(1)));
			if (!found && (!valid_q[i] || evict[i])) begin
				new_idx = IDX_W'(i);
				found   = 1'b1;
			end
		end
	end

	// value store write on every put
	assign ram_we    = cmd.update && (kind_q == KIND_PUT);
	assign ram_waddr = hit_s1 ? idx_s1 : new_idx;

	lkvc_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (ENTRIES)
	) u_values (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value_q),
		.raddr (match_idx),
		.rdata (ram_rdata)
	);

	// control state: valid marks, ranks, count, capacity, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= capacity;
			end
			if (cmd.update) begin
				if (hit_s1) begin
					// promote the hit entry, age the more recent ones
					for (int j = 0; j < ENTRIES; j++) begin
						if (valid_q[j] && (rank_q[j] < rank_s1)) begin
							rank_q[j] <= rank_q[j] + IDX_W'(1);
						end
					end
					rank_q[idx_s1] <= '0;
				end else if (kind_q == KIND_PUT) begin
					// drop least recent entries, age the rest, insert
					for (int j = 0; j < ENTRIES; j++) begin
						if (evict[j]) begin
							valid_q[j] <= 1'b0;
						end else if (valid_q[j]) begin
							rank_q[j] <= rank_q[j] + IDX_W'(1);
						end
					end
					valid_q[new_idx] <= 1'b1;
					rank_q[new_idx]  <= '0;
					count_q <= need_evict ? eff_cap : (count_q + CNT_W'(1));
				end
			end
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= value;
		end
		if (cmd.lookup) begin
			hit_s1  <= |match;
			idx_s1  <= match_idx;
			rank_s1 <= match_rank;
		end
		if (cmd.update && (kind_q == KIND_PUT) && !hit_s1) begin
			keys_q[new_idx] <= key_q;
		end
		if (cmd.update) begin
			hit_q <= hit_s1;
			if (kind_q == KIND_PUT) begin
				read_value_q <= PUT_VALUE;
			end else if (hit_s1) begin
				read_value_q <= ram_rdata;
			end else begin
				read_value_q <= MISS_VALUE;
			end
		end
	end

	assign status.out_blocked = out_valid_q && out_stall;
	assign out_valid          = out_valid_q;
	assign hit                = hit_q;
	assign read_value         = read_value_q;

endmodule
